[hdl/bqf_pkg.sv]
// shared types and constants of the biquad filter
package bqf_pkg;

	localparam int COEF_BITS    = 32;
	localparam int YFRAC        = 8;
	localparam int CHAN_BITS    = 1;
	localparam int REG_IDX_BITS = 3;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_B0,
		REG_B1,
		REG_B2,
		REG_A1,
		REG_A2
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_BITS-1:0] b0;
		logic signed [COEF_BITS-1:0] b1;
		logic signed [COEF_BITS-1:0] b2;
		logic signed [COEF_BITS-1:0] a1;
		logic signed [COEF_BITS-1:0] a2;
	} coef_t;

endpackage

[hdl/bqf_coef_regs.sv]
// coefficient register bank written through the configuration port
module bqf_coef_regs import bqf_pkg::*; #(
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [REG_IDX_BITS-1:0] cfg_idx,
	input  logic [COEF_BITS-1:0]    cfg_data,
	output coef_t                   coef
);

	localparam logic signed [COEF_BITS-1:0] UNITY = COEF_BITS'(1) << COEF_FRAC_BITS;

	coef_t coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= UNITY;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_B0: begin
					coef_q.b0 <= cfg_data;
				end
				REG_B1: begin
					coef_q.b1 <= cfg_data;
				end
				REG_B2: begin
					coef_q.b2 <= cfg_data;
				end
				REG_A1: begin
					coef_q.a1 <= cfg_data;
				end
				REG_A2: begin
					coef_q.a2 <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign coef = coef_q;

endmodule

[hdl/bqf_hist.sv]
// per-channel history of past inputs and past internal outputs
module bqf_hist import bqf_pkg::*; #(
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          we,
	input  logic [CHAN_BITS-1:0]          chan,
	input  logic signed [SAMPLE_BITS-1:0] x_new,
	input  logic signed [SAMPLE_BITS+YFRAC-1:0] y_new,
	output logic signed [SAMPLE_BITS-1:0] x1,
	output logic signed [SAMPLE_BITS-1:0] x2,
	output logic signed [SAMPLE_BITS+YFRAC-1:0] y1,
	output logic signed [SAMPLE_BITS+YFRAC-1:0] y2
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int YW    = SAMPLE_BITS + YFRAC;

	logic signed [SAMPLE_BITS-1:0] x1_q [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] x2_q [CHANNELS];
	logic signed [YW-1:0]          y1_q [CHANNELS];
	logic signed [YW-1:0]          y2_q [CHANNELS];
	logic [IDX_W-1:0]              idx;

	assign idx = IDX_W'(chan);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				x1_q[i] <= '0;
				x2_q[i] <= '0;
				y1_q[i] <= '0;
				y2_q[i] <= '0;
			end
		end else if (we) begin
			x2_q[idx] <= x1_q[idx];
			x1_q[idx] <= x_new;
			y2_q[idx] <= y1_q[idx];
			y1_q[idx] <= y_new;
		end
	end

	assign x1 = x1_q[idx];
	assign x2 = x2_q[idx];
	assign y1 = y1_q[idx];
	assign y2 = y2_q[idx];

endmodule

[hdl/bqf_mac.sv]
// multiply-accumulate, rounding and saturation for one sample
module bqf_mac import bqf_pkg::*; #(
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 28
) (
	input  coef_t                               coef,
	input  logic signed [SAMPLE_BITS-1:0]       x,
	input  logic signed [SAMPLE_BITS-1:0]       x1,
	input  logic signed [SAMPLE_BITS-1:0]       x2,
	input  logic signed [SAMPLE_BITS+YFRAC-1:0] y1,
	input  logic signed [SAMPLE_BITS+YFRAC-1:0] y2,
	output logic signed [SAMPLE_BITS+YFRAC-1:0] y,
	output logic signed [SAMPLE_BITS-1:0]       sample,
	output logic                                clipped
);

	localparam int YW    = SAMPLE_BITS + YFRAC;
	localparam int PW    = COEF_BITS + YW;
	localparam int ACC_W = PW + 3;
	localparam int RW    = YW + 1;

	localparam logic signed [ACC_W-1:0] RND   = ACC_W'(1) << (COEF_FRAC_BITS - 1);
	localparam logic signed [ACC_W-1:0] Y_MAX = {{(ACC_W-YW+1){1'b0}}, {(YW-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] Y_MIN = {{(ACC_W-YW+1){1'b1}}, {(YW-1){1'b0}}};
	localparam logic signed [RW-1:0]    O_RND = RW'(1) << (YFRAC - 1);
	localparam logic signed [RW-1:0]    S_MAX = {{(RW-SAMPLE_BITS+1){1'b0}},
		{(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [RW-1:0]    S_MIN = {{(RW-SAMPLE_BITS+1){1'b1}},
		{(SAMPLE_BITS-1){1'b0}}};

	logic signed [YW-1:0]    xv, x1v, x2v;
	logic signed [PW-1:0]    p_b0, p_b1, p_b2, p_a1, p_a2;
	logic signed [ACC_W-1:0] acc, y_wide;
	logic                    y_clip, s_clip;
	logic signed [RW-1:0]    r_wide, s_wide;

	// samples carry the same fraction alignment as internal y
	assign xv  = {x,  {YFRAC{1'b0}}};
	assign x1v = {x1, {YFRAC{1'b0}}};
	assign x2v = {x2, {YFRAC{1'b0}}};

	assign p_b0 = coef.b0 * xv;
	assign p_b1 = coef.b1 * x1v;
	assign p_b2 = coef.b2 * x2v;
	assign p_a1 = coef.a1 * y1;
	assign p_a2 = coef.a2 * y2;

	always_comb begin
		acc = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
			- ACC_W'(p_a1) - ACC_W'(p_a2) + RND;
		y_wide = acc >>> COEF_FRAC_BITS;
		y_clip = 1'b1;
		if (y_wide > Y_MAX) begin
			y = Y_MAX[YW-1:0];
		end else if (y_wide < Y_MIN) begin
			y = Y_MIN[YW-1:0];
		end else begin
			y      = y_wide[YW-1:0];
			y_clip = 1'b0;
		end

		r_wide = RW'(y) + O_RND;
		s_wide = r_wide >>> YFRAC;
		s_clip = 1'b1;
		if (s_wide > S_MAX) begin
			sample = S_MAX[SAMPLE_BITS-1:0];
		end else if (s_wide < S_MIN) begin
			sample = S_MIN[SAMPLE_BITS-1:0];
		end else begin
			sample = s_wide[SAMPLE_BITS-1:0];
			s_clip = 1'b0;
		end
		clipped = y_clip | s_clip;
	end

endmodule

[hdl/biquad_iir_filter.sv]
// top level of the multi-channel direct form I biquad filter
// One word per channel sample in, one word out. A word is registered on
// input, the whole multiply-accumulate with both roundings and saturations
// runs combinationally on the registered word, and the result lands in the
// output register. A new word is taken every cycle for any mix of channels
// while the output is not stalled, which the channel history recursion allows.
// History is cleared by reset and coefficients reset to passthrough.
// A channel number at or above CHANNELS returns a zero sample, not clipped,
// and leaves all history untouched. Coefficients are signed Q3 with
// COEF_FRAC_BITS fraction bits and should be written only while idle.
module biquad_iir_filter import bqf_pkg::*; #(
	parameter int CHANNELS       = 2,
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// sample_in
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// chan
	input  logic [CHAN_BITS-1:0]    s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// sample_out
	output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	// chan_out, clipped
	output logic [CHAN_BITS:0]      m_axis_tuser,
	input  logic                    cfg_we,
	input  logic [REG_IDX_BITS-1:0] cfg_idx,
	input  logic [COEF_BITS-1:0]    cfg_data
);

	localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int YW      = SAMPLE_BITS + YFRAC;

	coef_t                         coef;
	logic                          valid_s1, valid_s2;
	logic [CHAN_BITS-1:0]          chan_s1, chan_s2;
	logic signed [SAMPLE_BITS-1:0] x_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s2;
	logic                          clipped_s2;
	logic                          take, adv, chan_ok;
	logic signed [SAMPLE_BITS-1:0] x1, x2, mac_sample;
	logic signed [YW-1:0]          y1, y2, mac_y;
	logic                          mac_clip;

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;
	assign take          = s_axis_tvalid && s_axis_tready;
	assign chan_ok       = int'(chan_s1) < CHANNELS;

	bqf_coef_regs #(
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_coef (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.coef    (coef)
	);

	bqf_hist #(
		.CHANNELS   (CHANNELS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (adv && chan_ok),
		.chan  (chan_s1),
		.x_new (x_s1),
		.y_new (mac_y),
		.x1    (x1),
		.x2    (x2),
		.y1    (y1),
		.y2    (y2)
	);

	bqf_mac #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.COEF_FRAC_BITS(COEF_FRAC_BITS)
	) u_mac (
		.coef   (coef),
		.x      (x_s1),
		.x1     (x1),
		.x2     (x2),
		.y1     (y1),
		.y2     (y2),
		.y      (mac_y),
		.sample (mac_sample),
		.clipped(mac_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			chan_s1 <= s_axis_tuser;
			x_s1    <= s_axis_tdata[SAMPLE_BITS-1:0];
		end
		if (adv) begin
			chan_s2    <= chan_s1;
			sample_s2  <= chan_ok ? mac_sample : '0;
			clipped_s2 <= chan_ok && mac_clip;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = TDATA_W'($unsigned(sample_s2));
	assign m_axis_tuser  = {clipped_s2, chan_s2};

	// a full pipeline with a stalled output must refuse new words
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_axis_tready |-> !s_axis_tready)
		else $error("input taken while pipeline is blocked");

	// a word moved into the output register is presented next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid)
		else $error("result lost after advance");

	// any saturation leaves the output sample on a rail
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && clipped_s2 |->
			sample_s2 == {1'b0, {(SAMPLE_BITS-1){1'b1}}} ||
			sample_s2 == {1'b1, {(SAMPLE_BITS-1){1'b0}}})
		else $error("clipped word not at full scale");

endmodule

[tb/biquad_check.sv]
`timescale 1ns / 100ps
// checker of the biquad filter: predicts each output word and compares it with the block
module biquad_check import bqf_pkg::*; #(
	parameter int CHANNELS       = 2,
	parameter int SAMPLE_BITS    = 24,
	parameter int COEF_FRAC_BITS = 28
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_axis_tvalid,
	input  logic                    s_axis_tready,
	// sample_in
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
	// chan
	input  logic [CHAN_BITS-1:0]    s_axis_tuser,
	input  logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// sample_out
	input  logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
	// chan_out, clipped
	input  logic [CHAN_BITS:0]      m_axis_tuser,
	input  logic                    cfg_we,
	input  logic [REG_IDX_BITS-1:0] cfg_idx,
	input  logic [COEF_BITS-1:0]    cfg_data,
	output int                      pending,
	output int                      fail_count
);

	localparam int NUM_COEFS = int'(REG_A2) + 1;
	localparam int Y_BITS    = SAMPLE_BITS + YFRAC;
	localparam int ACC_BITS  = 2 * COEF_BITS + 8;

	localparam logic signed [ACC_BITS-1:0] Y_MAX = (ACC_BITS'(1) <<< (Y_BITS - 1)) - 1;
	localparam logic signed [ACC_BITS-1:0] Y_MIN = -Y_MAX - 1;
	localparam logic signed [ACC_BITS-1:0] S_MAX = (ACC_BITS'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam logic signed [ACC_BITS-1:0] S_MIN = -S_MAX - 1;
	localparam logic signed [COEF_BITS-1:0] UNITY = COEF_BITS'(1) <<< COEF_FRAC_BITS;

	typedef struct packed {
		logic [CHAN_BITS-1:0]          chan;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic                          clipped;
	} filter_word_t;

	logic signed [COEF_BITS-1:0]   coef   [NUM_COEFS];
	logic signed [SAMPLE_BITS-1:0] x_d1   [CHANNELS];
	logic signed [SAMPLE_BITS-1:0] x_d2   [CHANNELS];
	logic signed [Y_BITS-1:0]      y_d1   [CHANNELS];
	logic signed [Y_BITS-1:0]      y_d2   [CHANNELS];
	filter_word_t                  awaited_outputs [$];
	filter_word_t                  want;
	int                            mismatches;

	function automatic logic signed [ACC_BITS-1:0] wide(input logic signed [ACC_BITS-1:0] v);
		return v;
	endfunction

	function automatic filter_word_t next_filtered_word(input logic [CHAN_BITS-1:0] ch,
			input logic signed [SAMPLE_BITS-1:0] x);
		filter_word_t w;
		logic signed [ACC_BITS-1:0] acc;
		logic signed [ACC_BITS-1:0] yv;
		logic signed [ACC_BITS-1:0] sv;
		logic clip;
		w.chan = ch;
		w.sample = '0;
		w.clipped = 1'b0;
		if (ch >= CHANNELS)
			return w;
		clip = 1'b0;
		acc = wide(coef[REG_B0]) * (wide(x) <<< YFRAC)
			+ wide(coef[REG_B1]) * (wide(x_d1[ch]) <<< YFRAC)
			+ wide(coef[REG_B2]) * (wide(x_d2[ch]) <<< YFRAC)
			- wide(coef[REG_A1]) * wide(y_d1[ch])
			- wide(coef[REG_A2]) * wide(y_d2[ch])
			+ (ACC_BITS'(1) <<< (COEF_FRAC_BITS - 1));
		yv = acc >>> COEF_FRAC_BITS;
		if (yv > Y_MAX) begin
			yv = Y_MAX;
			clip = 1'b1;
		end else if (yv < Y_MIN) begin
			yv = Y_MIN;
			clip = 1'b1;
		end
		sv = (yv + (ACC_BITS'(1) <<< (YFRAC - 1))) >>> YFRAC;
		if (sv > S_MAX) begin
			sv = S_MAX;
			clip = 1'b1;
		end else if (sv < S_MIN) begin
			sv = S_MIN;
			clip = 1'b1;
		end
		x_d2[ch] = x_d1[ch];
		x_d1[ch] = x;
		y_d2[ch] = y_d1[ch];
		y_d1[ch] = yv[Y_BITS-1:0];
		w.sample = sv[SAMPLE_BITS-1:0];
		w.clipped = clip;
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (coef[i])
				coef[i] = '0;
			coef[REG_B0] = UNITY;
			for (int c = 0; c < CHANNELS; c++) begin
				x_d1[c] = '0;
				x_d2[c] = '0;
				y_d1[c] = '0;
				y_d2[c] = '0;
			end
			awaited_outputs.delete();
			mismatches = 0;
			pending <= 0;
			fail_count <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (awaited_outputs.size() == 0) begin
					$error("output word with none expected: chan_out %0d sample_out %0d clipped %0d",
						m_axis_tuser[CHAN_BITS-1:0], $signed(m_axis_tdata[SAMPLE_BITS-1:0]),
						m_axis_tuser[CHAN_BITS]);
					mismatches++;
				end else begin
					want = awaited_outputs.pop_front();
					if (m_axis_tuser[CHAN_BITS-1:0] !== want.chan) begin
						$error("chan_out: expected %0d, got %0d", want.chan,
							m_axis_tuser[CHAN_BITS-1:0]);
						mismatches++;
					end
					if (m_axis_tdata[SAMPLE_BITS-1:0] !== want.sample) begin
						$error("sample_out: expected %0d, got %0d", want.sample,
							$signed(m_axis_tdata[SAMPLE_BITS-1:0]));
						mismatches++;
					end
					if (m_axis_tuser[CHAN_BITS] !== want.clipped) begin
						$error("clipped: expected %0d, got %0d", want.clipped,
							m_axis_tuser[CHAN_BITS]);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				awaited_outputs.push_back(next_filtered_word(s_axis_tuser,
					s_axis_tdata[SAMPLE_BITS-1:0]));
			if (cfg_we && cfg_idx <= REG_A2)
				coef[cfg_idx] = cfg_data;
			pending <= awaited_outputs.size();
			fail_count <= mismatches;
		end
	end

endmodule

[tb/tb_biquad_iir_filter.sv]
`timescale 1ns / 100ps
// testbench top of the biquad filter: clock, reset, stimulus, flow control and verdict
module tb_biquad_iir_filter;
	import bqf_pkg::*;

	localparam int CHANNELS       = 2;
	localparam int SAMPLE_BITS    = 24;
	localparam int COEF_FRAC_BITS = 28;
	localparam int TDATA_BITS     = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int LONG_HOLD      = 200;
	localparam int DRAIN_CYCLES   = 8;
	localparam int PHASES         = 6;
	localparam int PHASE_WORDS    = 100;

	localparam logic signed [SAMPLE_BITS-1:0] SMP_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SMP_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic signed [COEF_BITS-1:0]   COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
	localparam logic signed [COEF_BITS-1:0]   COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
	localparam logic signed [COEF_BITS-1:0]   COEF_HALF = COEF_BITS'(1) <<< (COEF_FRAC_BITS - 1);

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [TDATA_BITS-1:0]   s_axis_tdata = '0;
	logic [CHAN_BITS-1:0]    s_axis_tuser = '0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [TDATA_BITS-1:0]   m_axis_tdata;
	logic [CHAN_BITS:0]      m_axis_tuser;
	logic                    cfg_we = 1'b0;
	logic [REG_IDX_BITS-1:0] cfg_idx = '0;
	logic [COEF_BITS-1:0]    cfg_data = '0;

	int send_idle_pct = 13;
	int recv_idle_pct = 80;
	int hold_req = 0;
	int pending;
	int fail_count;

	logic signed [SAMPLE_BITS-1:0] corner_samples [5] = '{SMP_MAX, SMP_MIN,
		SAMPLE_BITS'(0), SAMPLE_BITS'(1), SAMPLE_BITS'(-1)};

	always #4 clk = ~clk;

	biquad_iir_filter #(
		.CHANNELS       (CHANNELS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data)
	);

	biquad_check #(
		.CHANNELS       (CHANNELS),
		.SAMPLE_BITS    (SAMPLE_BITS),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_idx       (cfg_idx),
		.cfg_data      (cfg_data),
		.pending       (pending),
		.fail_count    (fail_count)
	);

	function automatic logic signed [COEF_BITS-1:0] rand_coef(input int mag_bits);
		return $signed($urandom) >>> (COEF_BITS - mag_bits);
	endfunction

	task automatic send_word(input logic [CHAN_BITS-1:0] ch,
			input logic signed [SAMPLE_BITS-1:0] smp);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= smp;
		s_axis_tuser  <= ch;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	task automatic drain_pipeline();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [REG_IDX_BITS-1:0] idx, input logic [COEF_BITS-1:0] val);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic set_coefs(input coef_t c);
		cfg_write(REG_B0, c.b0);
		cfg_write(REG_B1, c.b1);
		cfg_write(REG_B2, c.b2);
		cfg_write(REG_A1, c.a1);
		cfg_write(REG_A2, c.a2);
		// unused index, must be ignored
		cfg_write(REG_IDX_BITS'($urandom_range(2**REG_IDX_BITS - 1, int'(REG_A2) + 1)),
			$urandom);
		cfg_we <= 1'b0;
	endtask

	initial begin : receiver
		int hold_left;
		int hold_seen;
		hold_left = 0;
		hold_seen = 0;
		forever begin
			@(posedge clk);
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		#2_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin : stimulus
		coef_t                         cset;
		logic signed [SAMPLE_BITS-1:0] smp;
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// passthrough after reset
		for (int ch = 0; ch < CHANNELS; ch++)
			foreach (corner_samples[i])
				send_word(CHAN_BITS'(ch), corner_samples[i]);

		// half gain, round half up
		drain_pipeline();
		set_coefs('{COEF_HALF, 0, 0, 0, 0});
		send_word(1'b0, SAMPLE_BITS'(1));
		send_word(1'b0, SAMPLE_BITS'(-1));
		send_word(1'b1, SAMPLE_BITS'(3));
		send_word(1'b1, SAMPLE_BITS'(-3));

		drain_pipeline();
		set_coefs('{COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX});
		send_word(1'b0, SMP_MAX);
		send_word(1'b1, SMP_MIN);
		send_word(1'b0, SMP_MAX);
		send_word(1'b1, SAMPLE_BITS'(0));

		drain_pipeline();
		set_coefs('{COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN});
		send_word(1'b0, SMP_MIN);
		send_word(1'b1, SMP_MAX);
		send_word(1'b0, SAMPLE_BITS'(1));
		send_word(1'b1, SMP_MIN);

		for (int p = 0; p < PHASES; p++) begin
			drain_pipeline();
			case (p / 2)
				0: begin
					send_idle_pct = 13;
					recv_idle_pct = 80;
				end
				1: begin
					send_idle_pct = 80;
					recv_idle_pct = 13;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (p)
				0: cset = '{32'sd18119393, 32'sd36238786, 32'sd18119393,
					-32'sd306821727, 32'sd110810157};
				1: cset = '{rand_coef(29), rand_coef(29), rand_coef(29),
					rand_coef(29), rand_coef(29)};
				2: cset = '{COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX};
				4: cset = '{rand_coef(28), rand_coef(28), rand_coef(28),
					rand_coef(28), rand_coef(28)};
				default: cset = '{rand_coef(32), rand_coef(32), rand_coef(32),
					rand_coef(32), rand_coef(32)};
			endcase
			set_coefs(cset);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (p == 1 && n == PHASE_WORDS / 2)
					hold_req <= hold_req + 1;
				case ($urandom_range(9))
					0: smp = $urandom_range(1) ? SMP_MAX : SMP_MIN;
					1, 2: smp = SAMPLE_BITS'(int'($urandom_range(511)) - 256);
					default: smp = SAMPLE_BITS'($urandom);
				endcase
				send_word(CHAN_BITS'($urandom_range(1)), smp);
			end
		end

		drain_pipeline();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/bqf_pkg.sv
hdl/bqf_coef_regs.sv
hdl/bqf_hist.sv
hdl/bqf_mac.sv
hdl/biquad_iir_filter.sv
tb/biquad_check.sv
tb/tb_biquad_iir_filter.sv
